>>> rtl/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types, opcodes and sizes of the stack bytecode executor.
// ----------------------------------------------------------------------------
package sbe_pkg;

  localparam int unsigned OperandDepth = 64;
  localparam int unsigned CallDepth    = 16;
  localparam int unsigned LocalSlots   = 16;
  localparam int unsigned ProgramSize  = 1024;

  localparam int unsigned OpPtrW = $clog2(OperandDepth + 1);
  localparam int unsigned OpIdxW = $clog2(OperandDepth);
  localparam int unsigned LvlW   = $clog2(CallDepth);
  localparam int unsigned SlotW  = $clog2(LocalSlots);
  localparam int unsigned PcW    = $clog2(ProgramSize);
  localparam int unsigned LocW   = LvlW + SlotW;

  localparam logic [4:0] OpIload  = 5'd0;
  localparam logic [4:0] OpIconst = 5'd1;
  localparam logic [4:0] OpIstore = 5'd2;
  localparam logic [4:0] OpIadd   = 5'd3;
  localparam logic [4:0] OpIsub   = 5'd4;
  localparam logic [4:0] OpImul   = 5'd5;
  localparam logic [4:0] OpIdiv   = 5'd6;
  localparam logic [4:0] OpIlt    = 5'd7;
  localparam logic [4:0] OpIgt    = 5'd8;
  localparam logic [4:0] OpIeq    = 5'd9;
  localparam logic [4:0] OpIand   = 5'd10;
  localparam logic [4:0] OpIor    = 5'd11;
  localparam logic [4:0] OpInot   = 5'd12;
  localparam logic [4:0] OpGoto   = 5'd13;
  localparam logic [4:0] OpIfz    = 5'd14;
  localparam logic [4:0] OpCall   = 5'd15;
  localparam logic [4:0] OpRet    = 5'd16;
  localparam logic [4:0] OpPrint  = 5'd17;
  localparam logic [4:0] OpStop   = 5'd18;

  localparam logic [2:0] ErrNone  = 3'd0;
  localparam logic [2:0] ErrUnder = 3'd1;
  localparam logic [2:0] ErrOver  = 3'd2;
  localparam logic [2:0] ErrDiv0  = 3'd3;
  localparam logic [2:0] ErrOp    = 3'd4;
  localparam logic [2:0] ErrDeep  = 3'd5;
  localparam logic [2:0] ErrRet   = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the instruction and issue memory reads
    logic exec;     // operands are ready: evaluate and commit
    logic div_go;   // start the divider
    logic mul_go;   // start the multiplier
    logic fin;      // long op done: commit its result
  } sbe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic need_mul;
    logic div_done;
    logic mul_done;
  } sbe_sts_t;

endpackage

>>> rtl/sbe_divider.sv
// ----------------------------------------------------------------------------
// sbe_divider
// Radix-2 restoring divider for 32-bit signed quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module sbe_divider import sbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] q_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q; done_d = 1'b0;
    shifted = {rem_q[30:0], quo_q[31]};
    trial = {1'b0, shifted} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = a_i[31] ? (~a_i + 32'd1) : a_i;
      den_d = b_i[31] ? (~b_i + 32'd1) : b_i;
      neg_d = a_i[31] ^ b_i[31];
      cnt_d = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign q_o = neg_q ? (~quo_q + 32'd1) : quo_q;
endmodule

>>> rtl/sbe_datapath.sv
// ----------------------------------------------------------------------------
// sbe_datapath
// Stacks, frames, program counter and ALU of the stack bytecode executor.
// ----------------------------------------------------------------------------
module sbe_datapath import sbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbe_cmd_t           cmd_i,
  output sbe_sts_t           sts_o,
  input  logic [4:0]         op_i,
  input  logic signed [31:0] const_value_i,
  input  logic [3:0]         var_slot_i,
  input  logic [9:0]         jump_target_i,
  output logic [9:0]         next_pc_o,
  output logic               print_valid_o,
  output logic signed [31:0] print_value_o,
  output logic               halted_o,
  output logic [2:0]         error_code_o
);
  logic [31:0] opstk [OperandDepth];
  logic [PcW-1:0] retstk [CallDepth];
  logic [31:0] locmem [CallDepth*LocalSlots];
  logic [LocalSlots-1:0] written_q [CallDepth];

  logic [PcW-1:0]    pc_q, pc_d;
  logic [OpPtrW-1:0] sp_q, sp_d;
  logic [LvlW-1:0]   lvl_q, lvl_d;
  logic              halt_q, halt_d;

  logic [4:0]       op_q;
  logic [31:0]      cval_q;
  logic [SlotW-1:0] slot_q;
  logic [PcW-1:0]   tgt_q;
  logic [31:0]      top_q, sec_q, loc_q;
  logic             locv_q;
  logic [PcW-1:0]   ret_q;

  logic [31:0] mul_q, div_q, res;
  logic        mul_done_q, div_done;

  logic [OpIdxW-1:0] rd1, rd2;
  logic [PcW-1:0]    nxt, seq;
  logic [2:0]        err;
  logic              pvld;
  logic              push_en, wr_top;
  logic [OpIdxW-1:0] wr_idx;
  logic [31:0]       wr_val;
  logic              st_en, call_en;
  logic              is_bin;

  // read addresses, one and two below the pointer
  assign rd1 = OpIdxW'(sp_q - OpPtrW'(1));
  assign rd2 = OpIdxW'(sp_q - OpPtrW'(2));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      cval_q <= const_value_i;
      slot_q <= SlotW'(var_slot_i);
      tgt_q  <= PcW'(jump_target_i);
      top_q  <= opstk[rd1];
      sec_q  <= opstk[rd2];
      loc_q  <= locmem[{lvl_q, SlotW'(var_slot_i)}];
      locv_q <= written_q[lvl_q][SlotW'(var_slot_i)];
      ret_q  <= retstk[LvlW'(lvl_q - LvlW'(1))];
    end
  end

  assign is_bin = (op_q >= OpIadd) && (op_q <= OpIor);
  assign sts_o.need_div = !halt_q && (op_q == OpIdiv) && (sp_q >= OpPtrW'(2)) && (top_q != '0);
  assign sts_o.need_mul = !halt_q && (op_q == OpImul) && (sp_q >= OpPtrW'(2));
  assign sts_o.div_done = div_done;
  assign sts_o.mul_done = mul_done_q;

  sbe_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_go),
    .a_i    (sec_q),
    .b_i    (top_q),
    .done_o (div_done),
    .q_o    (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mul_done_q <= 1'b0;
    else         mul_done_q <= cmd_i.mul_go;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) mul_q <= sec_q * top_q;
  end

  always_comb begin
    seq = pc_q + PcW'(1);
    nxt = seq; err = ErrNone; pvld = 1'b0;
    push_en = 1'b0; wr_top = 1'b0; wr_idx = rd1; wr_val = '0;
    st_en = 1'b0; call_en = 1'b0;
    sp_d = sp_q; lvl_d = lvl_q; halt_d = halt_q; res = '0;
    unique case (op_q)
      OpIadd:  res = sec_q + top_q;
      OpIsub:  res = sec_q - top_q;
      OpImul:  res = mul_q;
      OpIdiv:  res = div_q;
      OpIlt:   res = {31'd0, $signed(sec_q) < $signed(top_q)};
      OpIgt:   res = {31'd0, $signed(top_q) < $signed(sec_q)};
      OpIeq:   res = {31'd0, sec_q == top_q};
      OpIand:  res = {31'd0, (sec_q != '0) && (top_q != '0)};
      OpIor:   res = {31'd0, (sec_q != '0) || (top_q != '0)};
      default: res = '0;
    endcase
    if (halt_q) begin
      nxt = pc_q;
    end else if (op_q == OpIload || op_q == OpIconst) begin
      if (sp_q >= OpPtrW'(OperandDepth)) err = ErrOver;
      else begin
        push_en = 1'b1; wr_idx = OpIdxW'(sp_q);
        wr_val = (op_q == OpIload) ? (locv_q ? loc_q : '0) : cval_q;
        sp_d = sp_q + OpPtrW'(1);
      end
    end else if (op_q == OpIstore || op_q == OpInot || op_q == OpIfz || op_q == OpPrint) begin
      if (sp_q == '0) err = ErrUnder;
      else if (op_q == OpInot) begin
        wr_top = 1'b1; wr_idx = rd1; wr_val = {31'd0, top_q != 32'd1};
      end else begin
        sp_d = sp_q - OpPtrW'(1);
        if (op_q == OpIstore) st_en = 1'b1;
        else if (op_q == OpIfz) begin
          if (top_q == '0) nxt = tgt_q;
        end else pvld = 1'b1;
      end
    end else if (is_bin) begin
      if (sp_q < OpPtrW'(2)) err = ErrUnder;
      else if (op_q == OpIdiv && top_q == '0) err = ErrDiv0;
      else begin
        wr_top = 1'b1; wr_idx = rd2; wr_val = res;
        sp_d = sp_q - OpPtrW'(1);
      end
    end else if (op_q == OpGoto) begin
      nxt = tgt_q;
    end else if (op_q == OpCall) begin
      if (lvl_q == LvlW'(CallDepth - 1)) err = ErrDeep;
      else begin
        call_en = 1'b1; lvl_d = lvl_q + LvlW'(1); nxt = tgt_q;
      end
    end else if (op_q == OpRet) begin
      if (lvl_q == '0) err = ErrRet;
      else begin
        lvl_d = lvl_q - LvlW'(1); nxt = ret_q;
      end
    end else if (op_q == OpStop) begin
      halt_d = 1'b1; nxt = pc_q;
    end else begin
      err = ErrOp;
    end
    pc_d = nxt;
  end

  logic commit;
  assign commit = cmd_i.exec || cmd_i.fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; sp_q <= '0; lvl_q <= '0; halt_q <= 1'b0;
      for (int i = 0; i < CallDepth; i++) written_q[i] <= '0;
      print_valid_o <= 1'b0; halted_o <= 1'b0; error_code_o <= ErrNone;
      next_pc_o <= '0;
    end else if (commit) begin
      pc_q <= pc_d; sp_q <= sp_d; lvl_q <= lvl_d; halt_q <= halt_d;
      if (st_en) written_q[lvl_q][slot_q] <= 1'b1;
      if (call_en) written_q[lvl_d] <= '0;
      next_pc_o <= pc_d; print_valid_o <= pvld; halted_o <= halt_d;
      error_code_o <= err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      print_value_o <= pvld ? top_q : '0;
      if (push_en || wr_top) opstk[wr_idx] <= wr_val;
      if (st_en) locmem[{lvl_q, slot_q}] <= top_q;
      if (call_en) retstk[lvl_q] <= seq;
    end
  end
endmodule

>>> rtl/sbe_control.sv
// ----------------------------------------------------------------------------
// sbe_control
// Sequencer: capture, execute or wait on a long unit, then hold the result.
// ----------------------------------------------------------------------------
module sbe_control import sbe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sbe_cmd_t cmd_o,
  input  sbe_sts_t sts_i
);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SExec = 2'd1;
  localparam logic [1:0] SWait = 2'd2;

  logic [1:0] state_q, state_d;
  logic       ov_q, ov_d;

  // a new transaction may enter once the previous result has left or leaves now
  assign in_ready_o  = (state_q == SIdle) && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d = ov_q && !out_ready_i;
    cmd_o = '0;
    unique case (state_q)
      SIdle: if (in_valid_i && in_ready_o) begin
        cmd_o.capture = 1'b1; state_d = SExec;
      end
      SExec: begin
        if (sts_i.need_div) begin
          cmd_o.div_go = 1'b1; state_d = SWait;
        end else if (sts_i.need_mul) begin
          cmd_o.mul_go = 1'b1; state_d = SWait;
        end else begin
          cmd_o.exec = 1'b1; ov_d = 1'b1; state_d = SIdle;
        end
      end
      SWait: if (sts_i.div_done || sts_i.mul_done) begin
        cmd_o.fin = 1'b1; ov_d = 1'b1; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d;
    end
  end
endmodule

>>> rtl/stack_bytecode_executor.sv
// ----------------------------------------------------------------------------
// stack_bytecode_executor
// Executes one stack-machine instruction per input transaction.
// ----------------------------------------------------------------------------
// The input channel carries one decoded instruction (op, immediate, local
// slot, jump target); the output channel returns one result per instruction:
// next pc, printed value, halt flag and error code.
// From acceptance to result, most instructions pass a capture step that reads the
// operand stack, frame store and return stack, then an execute step that commits.
// imul adds a wait on the registered multiplier, and idiv a wait on the
// bit-serial divider. One instruction is in flight at a time, and the
// next one is accepted in the cycle its predecessor's result is taken.
// A finished result sits in the output register; while the receiver stalls
// the block accepts no new transaction.
// Reset empties both stacks, returns to frame 0 with every local reading as
// zero, clears pc and halt; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stack_bytecode_executor import sbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         op_i,
  input  logic signed [31:0] const_value_i,
  input  logic [3:0]         var_slot_i,
  input  logic [9:0]         jump_target_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [9:0]         next_pc_o,
  output logic               print_valid_o,
  output logic signed [31:0] print_value_o,
  output logic               halted_o,
  output logic [2:0]         error_code_o
);
  sbe_cmd_t cmd;
  sbe_sts_t sts;

  sbe_control u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  sbe_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .op_i, .const_value_i, .var_slot_i, .jump_target_i,
    .next_pc_o, .print_valid_o, .print_value_o, .halted_o, .error_code_o
  );
endmodule
